[hdl/timed_step_schedule_fader_assert.svh]
// ----------------------------------------------------------------------------
// timed step schedule fader assertion macros
// shared property forms for the fader's concurrent checks
// ----------------------------------------------------------------------------
`ifndef TIMED_STEP_SCHEDULE_FADER_ASSERT_SVH
`define TIMED_STEP_SCHEDULE_FADER_ASSERT_SVH

// same-cycle implication, sampled on clk, off during reset
`define TSSF_ASSERT_IMPL(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, sampled on clk, off during reset
`define TSSF_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[hdl/tssf_pkg.sv]
// ----------------------------------------------------------------------------
// tssf_pkg
// types and constants of the timed step schedule fader
// ----------------------------------------------------------------------------
`default_nettype none

package tssf_pkg;

	localparam int STEP_COUNT   = 8;
	localparam int FADE_STEPS   = 10;
	localparam int SECS_PER_MIN = 60;

	localparam int IDX_W    = $clog2(STEP_COUNT);
	localparam int STEP_W   = 3;
	localparam int CH_COUNT = 3;
	localparam int LVL_W    = 8;
	localparam int FADE_W   = 4;
	localparam int HOUR_W   = 5;
	localparam int MIN_W    = 6;
	localparam int SEC_W    = 32;
	localparam int ACC_W    = 17;
	localparam int DELTA_W  = $clog2(255 * 256 / FADE_STEPS + 1) + 1;

	// constant divider: floor(x / DIV_DEN) = (x * RECIP) >> DIV_SH for x < 2**DIV_X_W
	localparam int DIV_DEN  = 2 * FADE_STEPS;
	localparam int DIV_X_W  = 17;
	localparam int DIV_SH   = DIV_X_W + $clog2(DIV_DEN);
	localparam int RECIP    = (2 ** DIV_SH + DIV_DEN - 1) / DIV_DEN;
	localparam int RECIP_W  = DIV_SH;

	typedef enum logic [1:0] {
		FUNC_WRITE   = 2'd0,
		FUNC_TICK    = 2'd1,
		FUNC_RESTART = 2'd2,
		FUNC_STOP    = 2'd3
	} func_t;

	typedef struct packed {
		func_t               func;
		logic [STEP_W-1:0]   step_index;
		logic                step_active;
		logic [HOUR_W-1:0]   step_hour;
		logic [MIN_W-1:0]    step_minute;
		logic [LVL_W-1:0]    step_red;
		logic [LVL_W-1:0]    step_white;
		logic [LVL_W-1:0]    step_blue;
		logic [HOUR_W-1:0]   now_hour;
		logic [MIN_W-1:0]    now_minute;
		logic [SEC_W-1:0]    now_seconds;
	} req_t;

	typedef struct packed {
		logic [LVL_W-1:0]    red_out;
		logic [LVL_W-1:0]    white_out;
		logic [LVL_W-1:0]    blue_out;
		logic                levels_changed;
		logic [STEP_W-1:0]   active_step;
		logic [FADE_W-1:0]   fade_remaining;
	} rsp_t;

	// channel 0 red, 1 white, 2 blue
	typedef struct packed {
		logic                            active;
		logic [HOUR_W-1:0]               hour;
		logic [MIN_W-1:0]                minute;
		logic [CH_COUNT-1:0][LVL_W-1:0]  lvl;
	} step_t;

endpackage

`default_nettype wire

[hdl/timed_step_schedule_fader.sv]
// ----------------------------------------------------------------------------
// timed_step_schedule_fader
// lighting step table with time-of-day selection and stepped level fades
// ----------------------------------------------------------------------------
// One item is taken at a time and gives one result. A step write, a stop or a
// tick while stopped goes from idle straight to the done state.
// A tick or restart walks the step table one entry per cycle through a single
// read port before the decide state picks the step in force; a fade start
// adds a pass of the delta state for each channel, since the three fade
// deltas share one reciprocal multiplier that also turns fade_minutes into the
// fade step period. A result waits in the output register while the next item
// is accepted; the engine holds a finished result only while that register is
// still full. Configuration writes are taken whenever the engine is idle.
// ----------------------------------------------------------------------------
`default_nettype none
`include "timed_step_schedule_fader_assert.svh"

module timed_step_schedule_fader
	import tssf_pkg::*;
(
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              req_valid,
	output logic                   req_stall,
	input  wire req_t              req_data,
	output logic                   rsp_valid,
	input  wire logic              rsp_stall,
	output rsp_t                   rsp_data,
	input  wire logic              cfg_valid,
	output logic                   cfg_ready,
	input  wire logic [LVL_W-1:0]  cfg_data
);

	typedef enum logic [8:0] {
		ST_IDLE   = 9'b000000001,
		ST_WALK   = 9'b000000010,
		ST_DECIDE = 9'b000000100,
		ST_SNAP   = 9'b000001000,
		ST_DELTA  = 9'b000010000,
		ST_TIME   = 9'b000100000,
		ST_CMP    = 9'b001000000,
		ST_STEP   = 9'b010000000,
		ST_DONE   = 9'b100000000
	} state_t;

	localparam int PROD_W = DIV_X_W + RECIP_W;
	localparam logic [RECIP_W-1:0] RECIP_C = RECIP_W'(RECIP);
	localparam step_t STEP_ON = '{active: 1'b1, hour: '0, minute: '0, lvl: '0};

	state_t                      state_q;
	step_t                       tbl_q [STEP_COUNT];
	logic [LVL_W-1:0]            fade_minutes_q;
	logic                        running_q;
	logic [IDX_W-1:0]            cur_q;
	logic [FADE_W-1:0]           fade_left_q;
	logic [SEC_W-1:0]            last_time_q;
	logic signed [ACC_W-1:0]     accum_q [CH_COUNT];
	logic signed [DELTA_W-1:0]   delta_q [CH_COUNT];
	logic [LVL_W-1:0]            level_q [CH_COUNT];

	func_t                       func_q;
	logic [HOUR_W-1:0]           now_hour_q;
	logic [MIN_W-1:0]            now_minute_q;
	logic [SEC_W-1:0]            now_seconds_q;
	logic                        changed_q;
	logic [IDX_W-1:0]            cnt_q;
	logic [IDX_W-1:0]            walk_last_q;
	logic                        walk_hit_q;
	logic                        walk_wrap_q;
	logic [1:0]                  ch_q;
	logic [DIV_X_W-1:0]          step_time_q;

	logic                        rsp_valid_q;
	rsp_t                        rsp_q;

	// combinational helpers
	logic [IDX_W-1:0]            rd_idx;
	step_t                       rd_ent;
	logic                        start_ahead;
	logic                        mid_active;
	logic                        flat;
	logic [IDX_W-1:0]            next_idx;
	logic [LVL_W:0]              diff;
	logic                        diff_neg;
	logic [LVL_W-1:0]            diff_mag;
	logic [DIV_X_W-1:0]          div_x;
	logic [PROD_W-1:0]           div_prod;
	logic [DIV_X_W-1:0]          div_q;
	logic signed [DELTA_W-1:0]   delta_mag;
	logic signed [DELTA_W-1:0]   delta_new;
	logic signed [ACC_W-1:0]     acc_sum [CH_COUNT];
	logic [LVL_W-1:0]            lvl_step [CH_COUNT];
	logic                        fade_due;
	logic                        req_xfer;
	logic                        rsp_free;

	assign req_stall = (state_q != ST_IDLE);
	assign req_xfer  = req_valid && !req_stall;
	assign cfg_ready = (state_q == ST_IDLE);
	assign rsp_valid = rsp_valid_q;
	assign rsp_data  = rsp_q;
	assign rsp_free  = !rsp_valid_q || !rsp_stall;

	// single table read port: walk pointer or the step in force
	always_comb begin
		rd_idx = (state_q == ST_WALK) ? cnt_q : cur_q;
		rd_ent = tbl_q[rd_idx];
		if (now_hour_q == rd_ent.hour) begin
			start_ahead = (now_minute_q < rd_ent.minute);
		end else begin
			start_ahead = (now_hour_q < rd_ent.hour);
		end
	end

	// basic program with matching first and last start picks step 0
	always_comb begin
		mid_active = 1'b0;
		for (int i = 1; i < STEP_COUNT - 1; i++) begin
			mid_active = mid_active | tbl_q[i].active;
		end
		flat = (fade_minutes_q == '0) && tbl_q[STEP_COUNT-1].active && !mid_active &&
			(tbl_q[0].hour == tbl_q[STEP_COUNT-1].hour) &&
			(tbl_q[0].minute == tbl_q[STEP_COUNT-1].minute);
		next_idx = flat ? '0 : walk_last_q;
	end

	// shared reciprocal divider: fade delta rounding and fade step period
	always_comb begin
		diff     = {1'b0, rd_ent.lvl[ch_q]} - {1'b0, level_q[ch_q]};
		diff_neg = diff[LVL_W];
		diff_mag = diff_neg ? LVL_W'(-diff) : diff[LVL_W-1:0];
		if (state_q == ST_TIME) begin
			div_x = DIV_X_W'({7'd0, fade_minutes_q} * 15'(2 * SECS_PER_MIN));
		end else begin
			div_x = {diff_mag, 9'd0} + DIV_X_W'(FADE_STEPS);
		end
		div_prod  = {{RECIP_W{1'b0}}, div_x} * {{DIV_X_W{1'b0}}, RECIP_C};
		div_q     = div_prod[DIV_SH +: DIV_X_W];
		delta_mag = DELTA_W'(div_q);
		delta_new = diff_neg ? -delta_mag : delta_mag;
	end

	// one fade step on all three channels, rounded and clamped
	always_comb begin
		logic signed [ACC_W:0] rnd;
		for (int c = 0; c < CH_COUNT; c++) begin
			acc_sum[c] = accum_q[c] + ACC_W'(delta_q[c]);
			rnd = (ACC_W+1)'(acc_sum[c]) + (ACC_W+1)'(128);
			if (rnd[ACC_W]) begin
				lvl_step[c] = '0;
			end else if (rnd[ACC_W-1:LVL_W+8] != '0) begin
				lvl_step[c] = '1;
			end else begin
				lvl_step[c] = rnd[LVL_W+7:8];
			end
		end
	end

	assign fade_due = ({1'b0, now_seconds_q} >= ({1'b0, last_time_q} + 33'(step_time_q)));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= ST_IDLE;
			for (int i = 0; i < STEP_COUNT; i++) begin
				tbl_q[i] <= (i == 0 || i == STEP_COUNT - 1) ? STEP_ON : '0;
			end
			fade_minutes_q <= '0;
			running_q      <= 1'b0;
			cur_q          <= '0;
			fade_left_q    <= '0;
			last_time_q    <= '0;
			for (int c = 0; c < CH_COUNT; c++) begin
				accum_q[c] <= '0;
				delta_q[c] <= '0;
				level_q[c] <= '0;
			end
			func_q         <= FUNC_WRITE;
			changed_q      <= 1'b0;
			cnt_q          <= '0;
			walk_last_q    <= '0;
			walk_hit_q     <= 1'b0;
			walk_wrap_q    <= 1'b0;
			ch_q           <= '0;
			rsp_valid_q    <= 1'b0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				fade_minutes_q <= cfg_data;
			end
			// a finished result in done reloads the register in the same cycle
			if (rsp_valid_q && !rsp_stall && state_q != ST_DONE) begin
				rsp_valid_q <= 1'b0;
			end

			case (state_q)
				ST_IDLE: begin
					if (req_xfer) begin
						func_q      <= req_data.func;
						changed_q   <= 1'b0;
						cnt_q       <= '0;
						walk_last_q <= '0;
						walk_hit_q  <= 1'b0;
						walk_wrap_q <= 1'b0;
						case (req_data.func)
							FUNC_WRITE: begin
								if (32'(req_data.step_index) < STEP_COUNT) begin
									tbl_q[IDX_W'(req_data.step_index)] <= '{
										active: req_data.step_active,
										hour:   req_data.step_hour,
										minute: req_data.step_minute,
										lvl:    {req_data.step_blue, req_data.step_white,
											req_data.step_red}};
								end
								state_q <= ST_DONE;
							end
							FUNC_TICK: begin
								state_q <= running_q ? ST_WALK : ST_DONE;
							end
							FUNC_RESTART: begin
								state_q <= ST_WALK;
							end
							FUNC_STOP: begin
								running_q <= 1'b0;
								state_q   <= ST_DONE;
							end
							default: begin
								state_q <= ST_DONE;
							end
						endcase
					end
				end

				ST_WALK: begin
					// last active start not after now; before the first one, wrap
					if (rd_ent.active && !walk_hit_q) begin
						if (start_ahead && !walk_wrap_q && cnt_q != '0) begin
							walk_hit_q <= 1'b1;
						end else begin
							walk_last_q <= cnt_q;
							if (start_ahead && cnt_q == '0) begin
								walk_wrap_q <= 1'b1;
							end
						end
					end
					if (32'(cnt_q) == STEP_COUNT - 1) begin
						cnt_q   <= '0;
						state_q <= ST_DECIDE;
					end else begin
						cnt_q <= cnt_q + 1'b1;
					end
				end

				ST_DECIDE: begin
					if (func_q == FUNC_RESTART) begin
						cur_q       <= next_idx;
						fade_left_q <= '0;
						running_q   <= 1'b1;
						changed_q   <= 1'b1;
						state_q     <= ST_SNAP;
					end else if (next_idx != cur_q) begin
						cur_q     <= next_idx;
						changed_q <= 1'b1;
						if (fade_minutes_q == '0) begin
							state_q <= ST_SNAP;
						end else begin
							fade_left_q <= FADE_W'(FADE_STEPS);
							ch_q        <= '0;
							state_q     <= ST_DELTA;
						end
					end else if (fade_left_q != '0) begin
						state_q <= ST_TIME;
					end else begin
						state_q <= ST_DONE;
					end
				end

				ST_SNAP: begin
					for (int c = 0; c < CH_COUNT; c++) begin
						level_q[c] <= rd_ent.lvl[c];
					end
					state_q <= ST_DONE;
				end

				ST_DELTA: begin
					delta_q[ch_q] <= delta_new;
					accum_q[ch_q] <= ACC_W'({level_q[ch_q], 8'd0});
					if (32'(ch_q) == CH_COUNT - 1) begin
						ch_q    <= '0;
						state_q <= ST_STEP;
					end else begin
						ch_q <= ch_q + 1'b1;
					end
				end

				ST_TIME: begin
					step_time_q <= div_q;
					state_q     <= ST_CMP;
				end

				ST_CMP: begin
					if (fade_due) begin
						changed_q <= 1'b1;
						if (fade_left_q == FADE_W'(1)) begin
							fade_left_q <= '0;
							state_q     <= ST_SNAP;
						end else begin
							state_q <= ST_STEP;
						end
					end else begin
						state_q <= ST_DONE;
					end
				end

				ST_STEP: begin
					fade_left_q <= fade_left_q - 1'b1;
					last_time_q <= now_seconds_q;
					for (int c = 0; c < CH_COUNT; c++) begin
						accum_q[c] <= acc_sum[c];
						level_q[c] <= lvl_step[c];
					end
					state_q <= ST_DONE;
				end

				ST_DONE: begin
					if (rsp_free) begin
						rsp_q.red_out        <= level_q[0];
						rsp_q.white_out      <= level_q[1];
						rsp_q.blue_out       <= level_q[2];
						rsp_q.levels_changed <= changed_q;
						rsp_q.active_step    <= STEP_W'(cur_q);
						rsp_q.fade_remaining <= fade_left_q;
						rsp_valid_q          <= 1'b1;
						state_q              <= ST_IDLE;
					end
				end

				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// item time fields, held for the whole item
	always_ff @(posedge clk) begin
		if (req_xfer) begin
			now_hour_q    <= req_data.now_hour;
			now_minute_q  <= req_data.now_minute;
			now_seconds_q <= req_data.now_seconds;
		end
	end

	`TSSF_ASSERT_NEXT(a_xfer_busy, req_xfer, state_q != ST_IDLE, "engine idle after transfer")
	`TSSF_ASSERT_IMPL(a_rsp_from_done, $rose(rsp_valid_q), $past(state_q) == ST_DONE, "result loaded outside done")
	`TSSF_ASSERT_IMPL(a_walk_cnt, cnt_q != '0, state_q == ST_WALK, "walk pointer off outside walk")
	`TSSF_ASSERT_IMPL(a_fade_range, state_q == ST_DONE, fade_left_q <= FADE_W'(FADE_STEPS), "fade count too large")

endmodule

`default_nettype wire

[tb/tb_top.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the timed step schedule fader. A short directed
// script covers the reset state, stops, restarts, flat and empty schedules,
// out-of-day start times, fades with late and wrapped seconds, and a fade
// length dropped mid-fade. Random phases then vary the fade length. Each
// result is checked against a local schedule model or a pinned value.
// ----------------------------------------------------------------------------
module tb_top;
	import tssf_pkg::*;

	localparam int CLK_HALF    = 6;
	localparam int RST_CYCLES  = 7;
	localparam int IDLE_LIMIT  = 2000;
	localparam int SETTLE      = 20;
	localparam int PHASE_ITEMS = 100;
	localparam int PHASES      = 9;

	typedef enum {RX_FREE, RX_RANDOM, RX_PERIODIC} rx_mode_t;

	typedef struct {
		bit                cfg;
		logic [LVL_W-1:0]  fade;
		req_t              req;
		bit                fixed;
		rsp_t              want;
	} script_row_t;

	localparam rsp_t SETTLED_DARK = '0;
	localparam rsp_t RESTARTED_DARK = '{red_out: 8'h00, white_out: 8'h00, blue_out: 8'h00,
		levels_changed: 1'b1, active_step: 3'd0, fade_remaining: 4'd0};

	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              req_valid = 1'b0;
	logic              req_stall;
	req_t              req_data = '0;
	logic              rsp_valid;
	logic              rsp_stall = 1'b0;
	rsp_t              rsp_data;
	logic              cfg_valid = 1'b0;
	logic              cfg_ready;
	logic [LVL_W-1:0]  cfg_data = '0;

	// typed-in expectation travelling with the presented item
	bit                cur_fixed = 1'b0;
	rsp_t              cur_want = '0;

	// schedule model
	step_t             sched [STEP_COUNT];
	logic [LVL_W-1:0]  fade_cfg = '0;
	bit                sched_run = 1'b0;
	logic [STEP_W-1:0] cur_step = '0;
	logic [FADE_W-1:0] fade_cnt = '0;
	logic [SEC_W-1:0]  last_step_sec = '0;
	int                accum [CH_COUNT] = '{default: 0};
	int                delta [CH_COUNT] = '{default: 0};
	logic [LVL_W-1:0]  level [CH_COUNT] = '{default: '0};

	rsp_t              expected_levels [$];
	script_row_t       script [$];
	int                errors = 0;
	int                idle_cycles = 0;

	int unsigned       day_minute = 0;
	logic [SEC_W-1:0]  clock_sec = '0;
	int                burst_left = 0;

	rx_mode_t          rx_mode = RX_FREE;
	int unsigned       rx_span = 0;
	logic [7:0]        rx_tick = '0;

	timed_step_schedule_fader uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.req_data  (req_data),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp_data  (rsp_data),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data)
	);

	initial begin
		forever #(CLK_HALF) clk = ~clk;
	end

	// ---------------- schedule model ----------------

	function automatic int prev_active(int upto);
		for (int i = upto; i > 0; i--) begin
			if (sched[i-1].active)
				return i - 1;
		end
		return 0;
	endfunction

	function automatic int select_step(logic [HOUR_W-1:0] h, logic [MIN_W-1:0] m);
		bit adv;
		bit early;
		if (fade_cfg == 0) begin
			// flat program: first and last only, same start, stays on the first
			adv = !sched[STEP_COUNT-1].active;
			for (int i = 1; i < STEP_COUNT - 1; i++) begin
				if (sched[i].active)
					adv = 1'b1;
			end
			if (!adv && sched[0].hour == sched[STEP_COUNT-1].hour &&
					sched[0].minute == sched[STEP_COUNT-1].minute)
				return 0;
		end
		for (int i = 0; i < STEP_COUNT; i++) begin
			if (!sched[i].active)
				continue;
			early = (h == sched[i].hour) ? (m < sched[i].minute) : (h < sched[i].hour);
			if (early)
				return prev_active(i == 0 ? STEP_COUNT : i);
		end
		return prev_active(STEP_COUNT);
	endfunction

	function automatic void load_step_levels();
		for (int c = 0; c < CH_COUNT; c++)
			level[c] = sched[cur_step].lvl[c];
	endfunction

	function automatic void fade_step_once(logic [SEC_W-1:0] now_s);
		int v;
		fade_cnt = fade_cnt - 1'b1;
		last_step_sec = now_s;
		for (int c = 0; c < CH_COUNT; c++) begin
			accum[c] += delta[c];
			v = (accum[c] + 128) / 256;
			if (accum[c] + 128 < 0)
				v = 0;
			if (v > 255)
				v = 255;
			level[c] = v[LVL_W-1:0];
		end
	endfunction

	// q8.8 step size, ties away from zero
	function automatic int q8_delta(int cur_lvl, int goal_lvl);
		int num;
		num = (goal_lvl - cur_lvl) * 256;
		if (num >= 0)
			return (2 * num + FADE_STEPS) / (2 * FADE_STEPS);
		return -((2 * (-num) + FADE_STEPS) / (2 * FADE_STEPS));
	endfunction

	function automatic rsp_t predict_levels(req_t r);
		rsp_t res;
		bit moved;
		int nxt;
		longint dt;
		longint period;
		moved = 1'b0;
		case (r.func)
			FUNC_WRITE: begin
				sched[r.step_index].active = r.step_active;
				sched[r.step_index].hour = r.step_hour;
				sched[r.step_index].minute = r.step_minute;
				sched[r.step_index].lvl[0] = r.step_red;
				sched[r.step_index].lvl[1] = r.step_white;
				sched[r.step_index].lvl[2] = r.step_blue;
			end
			FUNC_TICK: begin
				if (sched_run) begin
					nxt = select_step(r.now_hour, r.now_minute);
					if (nxt != cur_step) begin
						cur_step = STEP_W'(nxt);
						if (fade_cfg == 0) begin
							load_step_levels();
						end else begin
							fade_cnt = FADE_W'(FADE_STEPS);
							for (int c = 0; c < CH_COUNT; c++) begin
								delta[c] = q8_delta(int'(level[c]), int'(sched[nxt].lvl[c]));
								accum[c] = int'(level[c]) * 256;
							end
							fade_step_once(r.now_seconds);
						end
						moved = 1'b1;
					end else if (fade_cnt != 0) begin
						dt = longint'({32'd0, r.now_seconds}) - longint'({32'd0, last_step_sec});
						period = (longint'(fade_cfg) * SECS_PER_MIN) / FADE_STEPS;
						if (dt >= period) begin
							if (fade_cnt == 1) begin
								load_step_levels();
								fade_cnt = '0;
							end else begin
								fade_step_once(r.now_seconds);
							end
							moved = 1'b1;
						end
					end
				end
			end
			FUNC_RESTART: begin
				cur_step = STEP_W'(select_step(r.now_hour, r.now_minute));
				fade_cnt = '0;
				sched_run = 1'b1;
				load_step_levels();
				moved = 1'b1;
			end
			default: begin
				sched_run = 1'b0;
			end
		endcase
		res.red_out = level[0];
		res.white_out = level[1];
		res.blue_out = level[2];
		res.levels_changed = moved;
		res.active_step = cur_step;
		res.fade_remaining = fade_cnt;
		return res;
	endfunction

	// ---------------- stimulus helpers ----------------

	function automatic req_t noise_request();
		logic [95:0] bits96;
		bits96 = {$urandom, $urandom, $urandom};
		return bits96[$bits(req_t)-1:0];
	endfunction

	function automatic script_row_t row_cfg(logic [LVL_W-1:0] v);
		script_row_t row = '{cfg: 1'b1, fade: v, req: '0, fixed: 1'b0, want: '0};
		return row;
	endfunction

	function automatic script_row_t row_step(int idx, bit act, int h, int m,
			logic [LVL_W-1:0] r, logic [LVL_W-1:0] w, logic [LVL_W-1:0] b);
		script_row_t row = '{cfg: 1'b0, fade: '0, req: '0, fixed: 1'b0, want: '0};
		row.req = noise_request();
		row.req.func = FUNC_WRITE;
		row.req.step_index = STEP_W'(idx);
		row.req.step_active = act;
		row.req.step_hour = HOUR_W'(h);
		row.req.step_minute = MIN_W'(m);
		row.req.step_red = r;
		row.req.step_white = w;
		row.req.step_blue = b;
		return row;
	endfunction

	function automatic script_row_t row_time(func_t f, int h, int m, logic [SEC_W-1:0] sec);
		script_row_t row = '{cfg: 1'b0, fade: '0, req: '0, fixed: 1'b0, want: '0};
		row.req = noise_request();
		row.req.func = f;
		row.req.now_hour = HOUR_W'(h);
		row.req.now_minute = MIN_W'(m);
		row.req.now_seconds = sec;
		return row;
	endfunction

	function automatic script_row_t pin(script_row_t row, rsp_t want);
		row.fixed = 1'b1;
		row.want = want;
		return row;
	endfunction

	// mostly ticks on a slowly moving clock, with writes, restarts and stops
	function automatic req_t random_request(int unsigned period);
		req_t r;
		int unsigned pick;
		r = noise_request();
		pick = $urandom_range(0, 99);
		if (pick < 10) begin
			r.func = FUNC_WRITE;
			if ($urandom_range(0, 9) != 0) begin
				r.step_hour = HOUR_W'($urandom_range(0, 23));
				r.step_minute = MIN_W'($urandom_range(0, 59));
			end
		end else begin
			r.func = (pick < 14) ? FUNC_RESTART : (pick < 17) ? FUNC_STOP : FUNC_TICK;
			if ($urandom_range(0, 9) < 3)
				day_minute = (day_minute + $urandom_range(0, 120)) % 1440;
			case ($urandom_range(0, 19))
				0: clock_sec = $urandom;
				1: clock_sec = clock_sec - $urandom_range(1, 30);
				default: clock_sec = clock_sec + $urandom_range(0, period * 2 + 3);
			endcase
			r.now_seconds = clock_sec;
			if ($urandom_range(0, 19) != 0) begin
				r.now_hour = HOUR_W'(day_minute / 60);
				r.now_minute = MIN_W'(day_minute % 60);
			end
		end
		return r;
	endfunction

	task automatic send_request(req_t item, bit fixed, rsp_t want);
		req_valid <= 1'b1;
		req_data <= item;
		cur_fixed <= fixed;
		cur_want <= want;
		do @(posedge clk); while (req_stall !== 1'b0);
	endtask

	task automatic drain_results();
		req_valid <= 1'b0;
		do @(negedge clk); while (expected_levels.size() != 0);
		@(posedge clk);
	endtask

	task automatic set_fade(logic [LVL_W-1:0] v);
		drain_results();
		repeat (4) @(posedge clk);
		cfg_valid <= 1'b1;
		cfg_data <= v;
		do @(posedge clk); while (cfg_ready !== 1'b1);
		cfg_valid <= 1'b0;
	endtask

	task automatic pace_sender();
		int gap;
		if (burst_left == 0) begin
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
			if (gap != 0) begin
				req_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			burst_left = $urandom_range(1, 24);
		end
		burst_left--;
	endtask

	task automatic flag_field(string field, logic [31:0] want, logic [31:0] got);
		errors++;
		$display("%0t: %s mismatch, expected %0h, actual %0h", $time, field, want, got);
	endtask

	// ---------------- result checking ----------------

	always @(posedge clk) begin : scoreboard
		rsp_t want;
		rsp_t model_rsp;
		if (arst_n) begin
			if (rsp_valid === 1'b1 && rsp_stall === 1'b0) begin
				if (expected_levels.size() == 0) begin
					errors++;
					$display("%0t: result with none expected, actual %h", $time, rsp_data);
				end else begin
					want = expected_levels.pop_front();
					if (rsp_data.red_out !== want.red_out)
						flag_field("red_out", want.red_out, rsp_data.red_out);
					if (rsp_data.white_out !== want.white_out)
						flag_field("white_out", want.white_out, rsp_data.white_out);
					if (rsp_data.blue_out !== want.blue_out)
						flag_field("blue_out", want.blue_out, rsp_data.blue_out);
					if (rsp_data.levels_changed !== want.levels_changed)
						flag_field("levels_changed", want.levels_changed,
							rsp_data.levels_changed);
					if (rsp_data.active_step !== want.active_step)
						flag_field("active_step", want.active_step, rsp_data.active_step);
					if (rsp_data.fade_remaining !== want.fade_remaining)
						flag_field("fade_remaining", want.fade_remaining,
							rsp_data.fade_remaining);
				end
			end
			if (req_valid === 1'b1 && req_stall === 1'b0) begin
				model_rsp = predict_levels(req_data);
				expected_levels.push_back(cur_fixed ? cur_want : model_rsp);
			end
			if (cfg_valid === 1'b1 && cfg_ready === 1'b1)
				fade_cfg = cfg_data;
		end
	end

	// receiver stall pattern: free, random, or a fixed duty cycle
	always @(posedge clk) begin : rx_pattern
		rx_tick <= rx_tick + 1'b1;
		if (rx_span == 0) begin
			rx_mode <= rx_mode_t'($urandom_range(0, 2));
			rx_span <= $urandom_range(30, 200);
		end else begin
			rx_span <= rx_span - 1;
		end
		case (rx_mode)
			RX_FREE:   rsp_stall <= 1'b0;
			RX_RANDOM: rsp_stall <= ($urandom_range(0, 2) == 0);
			default:   rsp_stall <= (rx_tick[3:0] < 4'd11);
		endcase
	end

	always @(posedge clk) begin : watchdog
		if (!arst_n || (req_valid === 1'b1 && req_stall === 1'b0) ||
				(rsp_valid === 1'b1 && rsp_stall === 1'b0) ||
				(cfg_valid === 1'b1 && cfg_ready === 1'b1)) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= IDLE_LIMIT) begin
			$display("TB_ERROR");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	// ---------------- stimulus ----------------

	initial begin : stimulus
		int unsigned fade_plan [PHASES];
		bit quiet;
		foreach (sched[i])
			sched[i] = '0;
		sched[0].active = 1'b1;
		sched[STEP_COUNT-1].active = 1'b1;

		script.push_back(row_cfg(8'd0));
		script.push_back(pin(row_time(FUNC_STOP, 5, 5, 32'd7), SETTLED_DARK));
		script.push_back(pin(row_time(FUNC_TICK, 5, 5, 32'd8), SETTLED_DARK));
		// reset table: first and last steps both start at midnight
		script.push_back(pin(row_time(FUNC_RESTART, 12, 0, 32'd9), RESTARTED_DARK));
		script.push_back(pin(row_step(7, 1, 23, 59, 8'hff, 8'hff, 8'hff), SETTLED_DARK));
		script.push_back(row_time(FUNC_TICK, 23, 59, 32'd10));
		script.push_back(row_step(3, 1, 12, 30, 8'h80, 8'h40, 8'hc0));
		script.push_back(row_time(FUNC_TICK, 12, 30, 32'd11));
		// start time outside the day, reached by a tick at the same out-of-day time
		script.push_back(row_step(2, 1, 31, 63, 8'h01, 8'h02, 8'h03));
		script.push_back(row_time(FUNC_TICK, 31, 63, 32'hffff_ffff));
		// flat program
		script.push_back(row_step(2, 0, 0, 0, 8'h00, 8'h00, 8'h00));
		script.push_back(row_step(3, 0, 0, 0, 8'h00, 8'h00, 8'h00));
		script.push_back(row_step(7, 1, 0, 0, 8'h11, 8'h22, 8'h33));
		script.push_back(row_time(FUNC_TICK, 9, 0, 32'd12));
		// no active step at all falls back to the first
		script.push_back(row_step(0, 0, 0, 0, 8'h55, 8'haa, 8'h5a));
		script.push_back(row_step(7, 0, 0, 0, 8'h00, 8'h00, 8'h00));
		script.push_back(row_time(FUNC_RESTART, 6, 0, 32'd13));
		script.push_back(row_cfg(8'd1));
		script.push_back(row_step(0, 1, 0, 0, 8'h00, 8'h00, 8'h00));
		script.push_back(row_step(7, 1, 12, 0, 8'hff, 8'h80, 8'h01));
		script.push_back(row_time(FUNC_RESTART, 6, 0, 32'd100));
		script.push_back(row_time(FUNC_TICK, 12, 0, 32'd100));
		script.push_back(row_time(FUNC_TICK, 12, 0, 32'd106));
		// fade length dropped to zero while a fade is still running
		script.push_back(row_cfg(8'd0));
		script.push_back(row_time(FUNC_TICK, 12, 0, 32'd200));
		script.push_back(row_time(FUNC_TICK, 0, 30, 32'd201));
		script.push_back(row_time(FUNC_TICK, 0, 30, 32'd300));
		script.push_back(row_cfg(8'd255));
		script.push_back(row_time(FUNC_RESTART, 12, 0, 32'hffff_fff0));
		script.push_back(row_time(FUNC_TICK, 6, 0, 32'hffff_fff0));
		// seconds wrapped: negative elapsed time holds the fade
		script.push_back(row_time(FUNC_TICK, 6, 0, 32'd5));
		script.push_back(row_time(FUNC_STOP, 6, 0, 32'd6));

		fade_plan = '{0, 255, 1, 2, 0, 0, 255, 3, 1};
		fade_plan[5] = $urandom_range(4, 254);

		repeat (RST_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (script[i]) begin
			if (script[i].cfg)
				set_fade(script[i].fade);
			else
				send_request(script[i].req, script[i].fixed, script[i].want);
		end

		for (int phase = 0; phase < PHASES; phase++) begin
			set_fade(LVL_W'(fade_plan[phase]));
			quiet = (phase % 4 == 3);
			repeat (PHASE_ITEMS) begin
				if (!quiet)
					pace_sender();
				send_request(random_request(fade_plan[phase] * SECS_PER_MIN / FADE_STEPS),
					1'b0, '0);
			end
		end

		drain_results();
		repeat (SETTLE) @(posedge clk);
		if (errors == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule
